FILE: rtl/core/rpnm5_pkg.sv
// ----------------------------------------------------------------------------
// rpnm5_pkg
// Shared types, command and status codes and the mod-5 reduction for the
// RPN stack evaluator.
// ----------------------------------------------------------------------------
package rpnm5_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned IN_VAL_W  = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned RESIDUE_W = 3;
  localparam int unsigned DEPTH_W   = 6;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [IN_VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [RESIDUE_W-1:0] residue;
    logic                 entry_valid;
    logic [DEPTH_W-1:0]   depth;
    logic                 last;
  } out_beat_t;

  typedef struct packed {
    logic             start;
    logic [CMD_W-1:0] op;
  } alu_ctrl_t;

  // 256 and 16 are both 1 mod 5, so byte and nibble sums keep the residue
  function automatic logic [RESIDUE_W-1:0] mod5(input logic [63:0] v);
    logic [10:0] s1;
    logic [8:0]  s2;
    logic [8:0]  s3;
    logic [4:0]  s4;
    logic [4:0]  s5;
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 11'(v[8*i +: 8]);
    end
    s2 = 9'(s1[10:8]) + 9'(s1[7:0]);
    s3 = 9'(s2[8]) + 9'(s2[7:0]);
    s4 = 5'(s3[8]) + 5'(s3[7:4]) + 5'(s3[3:0]);
    s5 = 5'(s4[4]) + 5'(s4[3:0]);
    if (s5 >= 5'd15) begin
      s5 = s5 - 5'd15;
    end else if (s5 >= 5'd10) begin
      s5 = s5 - 5'd10;
    end else if (s5 >= 5'd5) begin
      s5 = s5 - 5'd5;
    end
    return s5[RESIDUE_W-1:0];
  endfunction

endpackage

FILE: rtl/core/rpn_mod5_stack_evaluator_core.sv
// ----------------------------------------------------------------------------
// rpn_mod5_stack_evaluator_core
// Reverse-polish stack evaluator reporting stack entries as residues mod 5.
// ----------------------------------------------------------------------------
// One command is taken at a time; the input is stalled until its last result
// beat has been loaded into the output register. Multiply and divide pass
// through the shared unit, which works one operand bit per cycle; add and
// subtract take a single step in it. The stack memory gives one registered
// read per cycle. A full output register that is stalled holds the
// sequencer until it drains.
module rpn_mod5_stack_evaluator_core
  import rpnm5_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RDA    = 4'd2;
  localparam logic [3:0] S_RDB    = 4'd3;
  localparam logic [3:0] S_ALU    = 4'd4;
  localparam logic [3:0] S_RD     = 4'd5;
  localparam logic [3:0] S_EMIT   = 4'd6;
  localparam logic [3:0] S_DRD    = 4'd7;
  localparam logic [3:0] S_DOUT   = 4'd8;

  logic [3:0]             state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [CMD_W-1:0]       cmd_q, cmd_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [VALUE_WIDTH-1:0] a_q, a_d;
  logic [STATUS_W-1:0]    status_q, status_d;
  out_beat_t              out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic [VALUE_WIDTH-1:0] mem_q [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  alu_ctrl_t              alu_ctrl;
  logic                   alu_done;
  logic [VALUE_WIDTH-1:0] alu_result;
  logic [RESIDUE_W-1:0]   rd_residue;
  logic                   out_free;

  assign rd_residue = mod5(64'(rdata_q));
  assign out_free   = !out_valid_q || !out_stall_i;

  rpnm5_alu #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (alu_ctrl),
    .a_i      (a_q),
    .b_i      (rdata_q),
    .divisor_i(rd_residue),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    a_d         = a_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_addr     = AW'(cnt_q - CW'(1));
    wr_en       = 1'b0;
    wr_addr     = cnt_q[AW-1:0];
    wr_data     = val_q;
    alu_ctrl    = '{start: 1'b0, op: cmd_q};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i.cmd;
          val_d   = VALUE_WIDTH'(in_data_i.value);
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        status_d = ST_OK;
        state_d  = S_RD;
        case (cmd_q)
          CMD_PUSH: begin
            if (cnt_q >= CW'(STACK_DEPTH)) begin
              status_d = ST_OVERFLOW;
            end else begin
              wr_en = 1'b1;
              cnt_d = cnt_q + CW'(1);
            end
          end
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
            if (cnt_q < CW'(2)) begin
              status_d = ST_UNDERFLOW;
            end else begin
              state_d = S_RDA;
            end
          end
          CMD_DUMP: begin
            if (cnt_q != '0) begin
              state_d = S_DRD;
            end
          end
          default: begin
          end
        endcase
      end
      S_RDA: begin
        a_d     = rdata_q;
        rd_addr = AW'(cnt_q - CW'(2));
        state_d = S_RDB;
      end
      S_RDB: begin
        cnt_d = cnt_q - CW'(2);
        if (cmd_q == CMD_DIV && rd_residue == '0) begin
          status_d = ST_DIV_ZERO;
          state_d  = S_RD;
        end else begin
          alu_ctrl.start = 1'b1;
          state_d        = S_ALU;
        end
      end
      S_ALU: begin
        if (alu_done) begin
          wr_en    = 1'b1;
          wr_data  = alu_result;
          cnt_d    = cnt_q + CW'(1);
          status_d = ST_OK;
          state_d  = S_RD;
        end
      end
      S_RD: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_d.status      = status_q;
          out_d.residue     = (cnt_q != '0) ? rd_residue : '0;
          out_d.entry_valid = (cnt_q != '0);
          out_d.depth       = DEPTH_W'(cnt_q);
          out_d.last        = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_DRD: begin
        state_d = S_DOUT;
      end
      S_DOUT: begin
        if (out_free) begin
          out_d.status      = ST_OK;
          out_d.residue     = rd_residue;
          out_d.entry_valid = 1'b1;
          out_d.depth       = '0;
          out_d.last        = (cnt_q == CW'(1));
          out_valid_d       = 1'b1;
          cnt_d             = cnt_q - CW'(1);
          state_d           = (cnt_q == CW'(1)) ? S_IDLE : S_DRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    val_q    <= val_d;
    a_q      <= a_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  // stack memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_alu_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> state_q == S_ALU)
    else $error("alu result with no operation waiting");

  a_dump_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last) |-> (out_data_o.depth == '0 &&
                                           out_data_o.entry_valid))
    else $error("non-final beat outside a dump");

endmodule

FILE: rtl/core/rpnm5_alu.sv
// ----------------------------------------------------------------------------
// rpnm5_alu
// Shared iterative arithmetic unit: add and subtract in one step, multiply
// by shift-and-add and divide by restoring division, one bit per step.
// ----------------------------------------------------------------------------
module rpnm5_alu
  import rpnm5_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  alu_ctrl_t              ctrl_i,
  input  logic [VALUE_WIDTH-1:0] a_i,
  input  logic [VALUE_WIDTH-1:0] b_i,
  input  logic [RESIDUE_W-1:0]   divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] result_o
);

  localparam int unsigned SW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_q;
  logic                   done_q;
  logic [SW-1:0]          steps_q;
  logic [CMD_W-1:0]       op_q;
  logic [VALUE_WIDTH-1:0] opa_q;
  logic [VALUE_WIDTH-1:0] opb_q;
  logic [VALUE_WIDTH-1:0] acc_q;
  logic [1:0]             rem_q;
  logic [RESIDUE_W-1:0]   div_q;

  logic [VALUE_WIDTH-1:0] add_x;
  logic [VALUE_WIDTH-1:0] add_y;
  logic                   add_cin;
  logic [VALUE_WIDTH-1:0] sum;
  logic [2:0]             trial;
  logic                   trial_ge;
  logic [1:0]             rem_d;

  always_comb begin
    if (op_q == CMD_MUL) begin
      add_x   = acc_q;
      add_y   = opb_q[0] ? opa_q : '0;
      add_cin = 1'b0;
    end else begin
      add_x   = opa_q;
      add_y   = (op_q == CMD_SUB) ? ~opb_q : opb_q;
      add_cin = (op_q == CMD_SUB);
    end
    sum = add_x + add_y + VALUE_WIDTH'(add_cin);
  end

  assign trial    = {rem_q, opa_q[VALUE_WIDTH-1]};
  assign trial_ge = (trial >= div_q);
  assign rem_d    = trial_ge ? 2'(trial - div_q) : trial[1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q  <= 1'b1;
        steps_q <= (ctrl_i.op == CMD_MUL || ctrl_i.op == CMD_DIV) ?
                   SW'(VALUE_WIDTH) : SW'(1);
      end else if (busy_q) begin
        steps_q <= steps_q - SW'(1);
        if (steps_q == SW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      op_q  <= ctrl_i.op;
      opa_q <= a_i;
      opb_q <= b_i;
      acc_q <= '0;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      case (op_q)
        CMD_MUL: begin
          acc_q <= sum;
          opa_q <= opa_q << 1;
          opb_q <= opb_q >> 1;
        end
        CMD_DIV: begin
          opa_q <= {opa_q[VALUE_WIDTH-2:0], trial_ge};
          rem_q <= rem_d;
        end
        default: begin
          acc_q <= sum;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = (op_q == CMD_DIV) ? opa_q : acc_q;

endmodule

FILE: test/rpn_mod5_checker.sv
// ----------------------------------------------------------------------------
// rpn_mod5_checker
// Watches both channels of the RPN mod-5 stack evaluator. It keeps its own
// copy of the stack, works out the result beats of every accepted command and
// compares each result beat, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module rpn_mod5_checker
  import rpnm5_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_beat_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_beat_t out_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        depth_o,
  output int        beats_o
);

  localparam int unsigned         ENTRIES = STACK_DEPTH_DEF;
  localparam logic [IN_VAL_W-1:0] MODULUS = 32'd5;
  localparam int                  RING    = 64;

  logic [IN_VAL_W-1:0] stack_vals [ENTRIES];
  int unsigned         stack_depth = 0;
  out_beat_t           exp_ring [RING];
  int                  wr_idx = 0;
  int                  rd_idx = 0;
  out_beat_t           want;
  int                  fails = 0;
  int                  beats_seen = 0;
  int                  pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign depth_o      = int'(stack_depth);
  assign beats_o      = beats_seen;

  task automatic enqueue_beat(input out_beat_t b);
    exp_ring[wr_idx % RING] = b;
    wr_idx++;
  endtask

  // single beat reporting the current top of stack
  function automatic out_beat_t top_report(input logic [STATUS_W-1:0] st);
    out_beat_t b;
    b        = '0;
    b.status = st;
    b.depth  = DEPTH_W'(stack_depth);
    b.last   = 1'b1;
    if (stack_depth > 0) begin
      b.entry_valid = 1'b1;
      b.residue     = RESIDUE_W'(stack_vals[stack_depth-1] % MODULUS);
    end
    return b;
  endfunction

  task automatic evaluate_command(input in_beat_t beat);
    logic [IN_VAL_W-1:0] top_v;
    logic [IN_VAL_W-1:0] next_v;
    logic [IN_VAL_W-1:0] res_v;
    logic [IN_VAL_W-1:0] divisor;
    out_beat_t           b;
    case (beat.cmd)
      CMD_PUSH: begin
        if (stack_depth >= ENTRIES) begin
          enqueue_beat(top_report(ST_OVERFLOW));
        end else begin
          stack_vals[stack_depth] = beat.value;
          stack_depth++;
          enqueue_beat(top_report(ST_OK));
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (stack_depth < 2) begin
          enqueue_beat(top_report(ST_UNDERFLOW));
        end else begin
          top_v       = stack_vals[stack_depth-1];
          next_v      = stack_vals[stack_depth-2];
          stack_depth = stack_depth - 2;
          divisor     = next_v % MODULUS;
          if (beat.cmd == CMD_DIV && divisor == '0) begin
            // both operands already gone
            enqueue_beat(top_report(ST_DIV_ZERO));
          end else begin
            case (beat.cmd)
              CMD_ADD: res_v = top_v + next_v;
              CMD_SUB: res_v = top_v - next_v;
              CMD_MUL: res_v = top_v * next_v;
              default: res_v = top_v / divisor;
            endcase
            stack_vals[stack_depth] = res_v;
            stack_depth++;
            enqueue_beat(top_report(ST_OK));
          end
        end
      end
      CMD_DUMP: begin
        if (stack_depth == 0) begin
          enqueue_beat(top_report(ST_OK));
        end else begin
          for (int k = int'(stack_depth) - 1; k >= 0; k--) begin
            b             = '0;
            b.status      = ST_OK;
            b.entry_valid = 1'b1;
            b.residue     = RESIDUE_W'(stack_vals[k] % MODULUS);
            b.last        = (k == 0);
            enqueue_beat(b);
          end
        end
        stack_depth = 0;
      end
      default: begin
        enqueue_beat(top_report(ST_OK));
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        evaluate_command(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        beats_seen++;
        if (wr_idx == rd_idx) begin
          fails++;
          $display("%0t: result beat with none expected:", $time);
          $display("%0t:   status %0d residue %0d valid %0d depth %0d last %0d",
                   $time, out_data_i.status, out_data_i.residue,
                   out_data_i.entry_valid, out_data_i.depth, out_data_i.last);
        end else begin
          want = exp_ring[rd_idx % RING];
          rd_idx++;
          if (want.status !== out_data_i.status || want.residue !== out_data_i.residue ||
              want.entry_valid !== out_data_i.entry_valid ||
              want.depth !== out_data_i.depth || want.last !== out_data_i.last) begin
            fails++;
            $display("%0t: beat mismatch, expected status %0d residue %0d valid %0d",
                     $time, want.status, want.residue, want.entry_valid);
            $display("%0t:   expected depth %0d last %0d", $time, want.depth, want.last);
            $display("%0t:   got      status %0d residue %0d valid %0d depth %0d last %0d",
                     $time, out_data_i.status, out_data_i.residue,
                     out_data_i.entry_valid, out_data_i.depth, out_data_i.last);
          end
        end
      end
      pending = wr_idx - rd_idx;
    end
  end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the RPN mod-5 stack evaluator with a directed opening (extremes,
// every command, underflow, divide by zero, wrap, empty dump, spare codes)
// followed by random command streams with stack fills past the top, while
// both channels stall at random. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import rpnm5_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 270;
  localparam int DRAIN_CYCLES = 80;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  int fail_count;
  int pending;
  int model_depth;
  int beats_checked;

  bit quiet      = 1'b0;
  int sent_total = 0;
  int sent_push  = 0;
  int sent_arith = 0;
  int sent_dump  = 0;
  int sent_spare = 0;

  logic [CMD_W-1:0] arith_ops [4] = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV};

  rpn_mod5_stack_evaluator_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  rpn_mod5_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .depth_o      (model_depth),
    .beats_o      (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send(input logic [CMD_W-1:0] op, input logic [IN_VAL_W-1:0] operand);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {op, operand};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent_total++;
    case (op)
      CMD_PUSH:                           sent_push++;
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: sent_arith++;
      CMD_DUMP:                           sent_dump++;
      default:                            sent_spare++;
    endcase
  endtask

  function automatic logic [IN_VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return IN_VAL_W'($urandom_range(0, 9));
      1:       return IN_VAL_W'(5 * $urandom_range(0, 1000)); // zero residue
      2:       return ~IN_VAL_W'($urandom_range(0, 9));
      default: return $urandom;
    endcase
  endfunction

  // result side back-pressure
  initial begin
    int hold;
    @(negedge clk);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped after %0d cycles with %0d beats outstanding", CYCLE_LIMIT, pending);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int r;
    int start_count;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opening
    send(CMD_ADD, '0);                 // underflow, empty
    send(CMD_DUMP, '0);                // empty dump
    send(CMD_PUSH, 32'hFFFF_FFFF);
    send(CMD_DIV, '0);                 // underflow, one entry
    send(CMD_PUSH, 32'h0000_0000);
    send(CMD_ADD, '0);
    send(CMD_PUSH, 32'h0000_0001);
    send(CMD_ADD, '0);                 // wraps to zero
    send(CMD_PUSH, 32'd7);
    send(CMD_PUSH, 32'd2);
    send(CMD_SUB, '0);                 // 2 - 7 wraps
    send(CMD_PUSH, 32'h8000_0001);
    send(CMD_MUL, '0);
    send(CMD_PUSH, 32'd10);
    send(CMD_PUSH, 32'd23);
    send(CMD_DIV, '0);                 // divisor residue zero
    send(CMD_PUSH, 32'd9);
    send(CMD_PUSH, 32'd1234567);
    send(CMD_DIV, '0);
    send(CMD_SPARE_6, '0);
    send(CMD_SPARE_7, 32'hFFFF_FFFF);
    send(CMD_PUSH, 32'hA5A5_A5A5);
    send(CMD_DUMP, 32'hFFFF_FFFF);
    send(CMD_SUB, '0);
    send(CMD_MUL, '0);

    start_count = sent_total;
    while (sent_total - start_count < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0: begin
          // fill, push past the top, then empty it
          while (model_depth < STACK_DEPTH_DEF) send(CMD_PUSH, rand_value());
          repeat ($urandom_range(1, 3)) send(CMD_PUSH, rand_value());
          send(CMD_DUMP, $urandom);
        end
        1: begin
          repeat (4) send(CMD_W'($urandom_range(0, 7)), $urandom);
        end
        default: begin
          repeat (20) begin
            r = $urandom_range(0, 99);
            if ((model_depth < 2 && r < 80) || r < 35) begin
              send(CMD_PUSH, rand_value());
            end else if (r < 92) begin
              send(arith_ops[$urandom_range(0, 3)], $urandom);
            end else if (r < 97) begin
              send(CMD_DUMP, $urandom);
            end else begin
              send(r[0] ? CMD_SPARE_7 : CMD_SPARE_6, $urandom);
            end
          end
        end
      endcase
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands: %0d pushes, %0d arithmetic, %0d dumps, %0d spare codes",
             sent_total, sent_push, sent_arith, sent_dump, sent_spare);
    $display("Checked %0d result beats, %0d failing", beats_checked, fail_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: rpn_mod5_stack_evaluator_core.f
rtl/core/rpnm5_pkg.sv
rtl/core/rpnm5_alu.sv
rtl/core/rpn_mod5_stack_evaluator_core.sv
test/rpn_mod5_checker.sv
test/testbench.sv
